// ===== design/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types and constants for the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;
	localparam int DEPTH = 256;
	localparam int IW = 9;
	localparam int AW = 8;
	localparam logic [IW-1:0] NONE = IW'(DEPTH);

	localparam logic [3:0] K_INS_FRONT = 4'd0;
	localparam logic [3:0] K_INS_REAR  = 4'd1;
	localparam logic [3:0] K_RM_FRONT  = 4'd2;
	localparam logic [3:0] K_RM_REAR   = 4'd3;
	localparam logic [3:0] K_RM_CUR    = 4'd4;
	localparam logic [3:0] K_SEARCH    = 4'd5;
	localparam logic [3:0] K_RETRIEVE  = 4'd6;
	localparam logic [3:0] K_PURGE     = 4'd7;
	localparam logic [3:0] K_CLEAR     = 4'd8;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [3:0]        kind;
		logic signed [31:0] value;
		logic [7:0]        position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [IW-1:0]      node_index;
		logic signed [31:0] node_value;
		logic [IW-1:0]      cursor;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_RD, S_WAIT, S_EVAL, S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic rd;
		logic eval;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_walk;
		logic walk_done;
	} sts_t;
endpackage

// ===== design/alle_if.sv =====
// ----------------------------------------------------------------------------
// alle_in_if / alle_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface alle_in_if;
	logic valid;
	logic ready;
	logic [3:0] kind;
	logic signed [31:0] value;
	logic [7:0] position;
	modport source(output valid, kind, value, position, input ready);
	modport sink(input valid, kind, value, position, output ready);
endinterface

interface alle_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [8:0] node_index;
	logic signed [31:0] node_value;
	logic [8:0] cursor;
	modport source(output valid, status, node_index, node_value, cursor, input ready);
	modport sink(input valid, status, node_index, node_value, cursor, output ready);
endinterface

// ===== design/alle_ctrl.sv =====
// ----------------------------------------------------------------------------
// alle_ctrl
// Sequencer: accepts a beat, drives the walk one node per memory read.
// ----------------------------------------------------------------------------
module alle_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  alle_pkg::sts_t  sts,
	output alle_pkg::cmd_t  cmd
);
	import alle_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.need_walk) begin
					cmd.rd = 1'b1;
					state_d = S_WAIT;
				end else begin
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end
			end
			// walk_done is registered, so it is seen in the cycle after the update
			S_RD: begin
				if (sts.walk_done) begin
					state_d = S_OUT;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_WAIT;
				end
			end
			S_WAIT: state_d = S_EVAL;
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = S_RD;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== design/alle_dp.sv =====
// ----------------------------------------------------------------------------
// alle_dp
// Node store, free list and per-operation walk datapath.
// ----------------------------------------------------------------------------
module alle_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [8:0]          cfg_data,
	input  alle_pkg::in_item_t  item,
	input  alle_pkg::cmd_t      cmd,
	output alle_pkg::sts_t      sts,
	output alle_pkg::out_item_t res
);
	import alle_pkg::*;

	logic [31:0]   data_mem [DEPTH];
	logic [IW-1:0] link_mem [DEPTH];
	logic [IW-1:0] free_mem [DEPTH];

	logic [IW-1:0] head_q, cur_q, hw_q, fhead_q, cap_q;
	logic [3:0]    kind_q;
	logic [31:0]   val_q;
	logic [7:0]    pos_q;
	logic [IW-1:0] p_q, prev_q, kept_q, cnt_q;
	logic [31:0]   key_q;
	logic          done_q;
	logic [1:0]    st_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   nval_q;

	// registered reads of the node at p and of the free link at the free head
	logic [31:0]   rdata_q;
	logic [IW-1:0] rlink_q, rfree_q;

	logic          has_p;
	logic [IW-1:0] caplim;
	logic          full;
	logic [IW-1:0] take;

	assign has_p = !p_q[IW-1];
	assign caplim = (cap_q == '0) ? IW'(1) : (cap_q > NONE ? NONE : cap_q);
	assign full = fhead_q[IW-1] && (hw_q >= caplim);
	assign take = !fhead_q[IW-1] ? fhead_q : hw_q;

	// reads: data and link of the node at p and the free link at the free head, together
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= data_mem[p_q[AW-1:0]];
			rlink_q <= link_mem[p_q[AW-1:0]];
			rfree_q <= free_mem[fhead_q[AW-1:0]];
		end
	end

	// the kinds that need the store read before they can finish
	always_comb begin
		sts.need_walk = 1'b0;
		sts.walk_done = done_q;
		case (kind_q)
			K_INS_FRONT: sts.need_walk = !full && !fhead_q[IW-1];
			K_INS_REAR:  sts.need_walk = !full;
			K_RM_FRONT, K_RM_REAR, K_SEARCH, K_CLEAR: sts.need_walk = !head_q[IW-1];
			K_RM_CUR, K_PURGE: sts.need_walk = !head_q[IW-1] && !cur_q[IW-1];
			K_RETRIEVE:  sts.need_walk = !head_q[IW-1];
			default:     sts.need_walk = 1'b0;
		endcase
	end

	assign res.status = st_q;
	assign res.node_index = idx_q;
	assign res.node_value = nval_q;
	assign res.cursor = cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NONE;
			cur_q <= NONE;
			hw_q <= '0;
			fhead_q <= NONE;
			cap_q <= NONE;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (cmd.start) begin
				kind_q <= item.kind;
				val_q <= item.value;
				pos_q <= item.position;
				p_q <= head_q;
				prev_q <= NONE;
				kept_q <= NONE;
				cnt_q <= '0;
				done_q <= 1'b0;
				st_q <= ST_NONE;
				idx_q <= NONE;
				nval_q <= '0;
			end
			if (cmd.finish) begin
				// paths with no store read
				if ((kind_q == K_INS_FRONT || kind_q == K_INS_REAR) && full) begin
					st_q <= ST_FULL;
				end else if (kind_q == K_INS_FRONT || kind_q == K_INS_REAR) begin
					// front insert into an untouched slot
					data_mem[take[AW-1:0]] <= val_q;
					link_mem[take[AW-1:0]] <= head_q;
					head_q <= take;
					cur_q <= take;
					hw_q <= hw_q + IW'(1);
					st_q <= ST_DONE;
					idx_q <= take;
					nval_q <= val_q;
				end else if (kind_q == K_CLEAR) begin
					cur_q <= NONE;
					st_q <= ST_DONE;
				end else if (kind_q == K_PURGE || kind_q == K_RM_CUR) begin
					st_q <= ST_NONE;
				end
			end
			if (cmd.eval) begin
				cnt_q <= cnt_q + IW'(1);
				case (kind_q)
					K_INS_FRONT: begin
						data_mem[take[AW-1:0]] <= val_q;
						link_mem[take[AW-1:0]] <= head_q;
						fhead_q <= rfree_q;
						head_q <= take;
						cur_q <= take;
						st_q <= ST_DONE;
						idx_q <= take;
						nval_q <= val_q;
						done_q <= 1'b1;
					end
					K_INS_REAR: begin
						if (head_q[IW-1] || rlink_q[IW-1] || cnt_q == NONE) begin
							if (!fhead_q[IW-1]) fhead_q <= rfree_q;
							else hw_q <= hw_q + IW'(1);
							data_mem[take[AW-1:0]] <= val_q;
							link_mem[take[AW-1:0]] <= NONE;
							if (head_q[IW-1]) head_q <= take;
							else link_mem[p_q[AW-1:0]] <= take;
							cur_q <= take;
							st_q <= ST_DONE;
							idx_q <= take;
							nval_q <= val_q;
							done_q <= 1'b1;
						end else p_q <= rlink_q;
					end
					K_RM_FRONT: begin
						free_mem[p_q[AW-1:0]] <= fhead_q;
						fhead_q <= p_q;
						head_q <= rlink_q;
						cur_q <= rlink_q;
						st_q <= ST_DONE;
						idx_q <= p_q;
						nval_q <= rdata_q;
						done_q <= 1'b1;
					end
					K_RM_REAR: begin
						if (rlink_q[IW-1] || cnt_q == NONE) begin
							free_mem[p_q[AW-1:0]] <= fhead_q;
							fhead_q <= p_q;
							if (prev_q[IW-1]) begin
								head_q <= NONE;
								cur_q <= NONE;
							end else begin
								link_mem[prev_q[AW-1:0]] <= NONE;
								cur_q <= prev_q;
							end
							st_q <= ST_DONE;
							idx_q <= p_q;
							nval_q <= rdata_q;
							done_q <= 1'b1;
						end else begin
							prev_q <= p_q;
							p_q <= rlink_q;
						end
					end
					K_RM_CUR: begin
						if (p_q == cur_q) begin
							free_mem[p_q[AW-1:0]] <= fhead_q;
							fhead_q <= p_q;
							if (prev_q[IW-1]) begin
								head_q <= rlink_q;
								cur_q <= rlink_q;
							end else begin
								link_mem[prev_q[AW-1:0]] <= rlink_q;
								cur_q <= prev_q;
							end
							st_q <= ST_DONE;
							idx_q <= p_q;
							nval_q <= rdata_q;
							done_q <= 1'b1;
						end else if (rlink_q[IW-1] || cnt_q == NONE) begin
							done_q <= 1'b1;
						end else begin
							prev_q <= p_q;
							p_q <= rlink_q;
						end
					end
					K_SEARCH: begin
						if (rdata_q == val_q) begin
							cur_q <= p_q;
							st_q <= ST_DONE;
							idx_q <= p_q;
							nval_q <= rdata_q;
							done_q <= 1'b1;
						end else if (rlink_q[IW-1] || cnt_q == NONE) begin
							done_q <= 1'b1;
						end else p_q <= rlink_q;
					end
					K_RETRIEVE: begin
						if (cnt_q[AW-1:0] == pos_q && !cnt_q[IW-1]) begin
							st_q <= ST_DONE;
							idx_q <= p_q;
							nval_q <= rdata_q;
							done_q <= 1'b1;
						end else if (rlink_q[IW-1]) begin
							done_q <= 1'b1;
						end else p_q <= rlink_q;
					end
					K_PURGE: begin
						// first pass to the cursor reads the key, then walk from head
						if (cnt_q == '0) begin
							p_q <= cur_q;
							kept_q <= NONE;
						end else if (cnt_q == IW'(1)) begin
							key_q <= rdata_q;
							p_q <= head_q;
						end else begin
							if (rdata_q == key_q && !kept_q[IW-1]) begin
								if (prev_q[IW-1]) head_q <= rlink_q;
								else link_mem[prev_q[AW-1:0]] <= rlink_q;
								free_mem[p_q[AW-1:0]] <= fhead_q;
								fhead_q <= p_q;
							end else begin
								if (rdata_q == key_q) begin
									kept_q <= p_q;
									idx_q <= p_q;
									nval_q <= rdata_q;
									cur_q <= p_q;
								end
								prev_q <= p_q;
							end
							if (rlink_q[IW-1]) begin
								st_q <= ST_DONE;
								done_q <= 1'b1;
							end else p_q <= rlink_q;
						end
					end
					K_CLEAR: begin
						free_mem[p_q[AW-1:0]] <= fhead_q;
						fhead_q <= p_q;
						if (rlink_q[IW-1]) begin
							head_q <= NONE;
							cur_q <= NONE;
							st_q <= ST_DONE;
							done_q <= 1'b1;
						end else p_q <= rlink_q;
					end
					default: done_q <= 1'b1;
				endcase
			end
		end
	end
endmodule

// ===== design/array_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_engine_unit
// Linked list of signed words in a 256-slot node store with a free list.
// ----------------------------------------------------------------------------
// One item at a time. Front inserts into an untouched slot, operations other
// than inserts on an empty list or without a cursor, unused kinds and
// full-store refusals pass through accept, dispatch and the result beat; every
// node read adds a read, the registered data and an update. A front insert
// from the free list reads one node for its free link; purge reads the head
// and the cursor node before walking the list. Results are held until taken;
// the next beat is accepted after that.
module array_linked_list_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_data,
	alle_in_if.sink     in_ch,
	alle_out_if.source  out_ch
);
	import alle_pkg::*;
	cmd_t cmd;
	sts_t sts;
	in_item_t item;
	out_item_t res;

	assign item.kind = in_ch.kind;
	assign item.value = in_ch.value;
	assign item.position = in_ch.position;
	assign out_ch.status = res.status;
	assign out_ch.node_index = res.node_index;
	assign out_ch.node_value = res.node_value;
	assign out_ch.cursor = res.cursor;

	alle_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	alle_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_data, .item, .cmd, .sts, .res
	);
endmodule
